// File: rtl/pat_pkg.sv
// shared types and constants of the program association section parser
package pat_pkg;

	localparam logic [9:0] MAX_PROGRAMS_RESET = 10'd20;
	localparam logic [11:0] MIN_SECT_LENGTH = 12'd9;
	localparam int OUT_DATA_W = 120;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_ENTRY  = 2'd1,
		PH_CRC    = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER      = 3'd0,
		KIND_ENTRY       = 3'd1,
		KIND_CRC         = 3'd2,
		KIND_SHORT_HDR   = 3'd3,
		KIND_TOO_MANY    = 3'd4,
		KIND_SHORT_ENTRY = 3'd5,
		KIND_SHORT_CRC   = 3'd6,
		KIND_BAD_LENGTH  = 3'd7
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  byte_pos;
		logic [9:0]  entries_left;
		logic [7:0]  table_ident;
		logic [6:0]  flags_version;
		logic [11:0] sect_length;
		logic [15:0] stream_ident;
		logic [15:0] sect_numbers;
		logic [23:0] collect_shift;
	} pat_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  table_ident;
		logic        syntax_flag;
		logic [11:0] sect_length;
		logic [15:0] stream_ident;
		logic [4:0]  version_num;
		logic        current_flag;
		logic [7:0]  sect_number;
		logic [7:0]  last_sect_number;
		logic [15:0] program_num;
		logic [12:0] map_pid;
		logic [31:0] crc_word;
	} pat_result_t;

endpackage

// File: rtl/pat_step.sv
// per-byte parse logic: next parser state and the result of one section byte
module pat_step (
	input  pat_pkg::pat_state_t  cur,
	input  logic [9:0]           max_programs,
	input  logic [7:0]           section_byte,
	input  logic                 is_last,
	output pat_pkg::pat_state_t  nxt,
	output logic                 res_valid,
	output pat_pkg::pat_result_t res
);

	pat_pkg::pat_state_t cap;
	logic [11:0] len_minus;
	logic [9:0]  cnt;
	logic        len_bad;
	logic        too_many;
	logic [9:0]  left_dec;

	function automatic pat_pkg::pat_result_t header_result(pat_pkg::pat_state_t s,
			pat_pkg::kind_t k);
		pat_pkg::pat_result_t r;
		r = '0;
		r.kind = k;
		r.table_ident = s.table_ident;
		r.syntax_flag = s.flags_version[6];
		r.sect_length = s.sect_length;
		r.stream_ident = s.stream_ident;
		r.version_num = s.flags_version[5:1];
		r.current_flag = s.flags_version[0];
		r.sect_number = s.sect_numbers[15:8];
		r.last_sect_number = s.sect_numbers[7:0];
		return r;
	endfunction

	// header field capture
	always_comb begin
		cap = cur;
		if (cur.phase == pat_pkg::PH_HEADER) begin
			case (cur.byte_pos)
				3'd0: cap.table_ident = section_byte;
				3'd1: begin
					cap.flags_version[6] = section_byte[7];
					cap.sect_length[11:8] = section_byte[3:0];
				end
				3'd2: cap.sect_length[7:0] = section_byte;
				3'd3: cap.stream_ident[15:8] = section_byte;
				3'd4: cap.stream_ident[7:0] = section_byte;
				3'd5: cap.flags_version[5:0] = section_byte[5:0];
				3'd6: cap.sect_numbers[15:8] = section_byte;
				default: cap.sect_numbers[7:0] = section_byte;
			endcase
		end
	end

	assign len_minus = cap.sect_length - pat_pkg::MIN_SECT_LENGTH;
	assign cnt = len_minus[11:2];
	assign len_bad = cap.sect_length < pat_pkg::MIN_SECT_LENGTH;
	assign too_many = cnt > max_programs;
	assign left_dec = cur.entries_left - 10'd1;

	// next state
	always_comb begin
		nxt = cap;
		case (cur.phase)
			pat_pkg::PH_HEADER: begin
				if (cur.byte_pos < 3'd7) begin
					nxt.byte_pos = is_last ? 3'd0 : cur.byte_pos + 3'd1;
				end else begin
					nxt.byte_pos = 3'd0;
					if (len_bad || too_many) begin
						nxt.phase = is_last ? pat_pkg::PH_HEADER : pat_pkg::PH_DONE;
					end else begin
						nxt.entries_left = cnt;
						if (is_last)
							nxt.phase = pat_pkg::PH_HEADER;
						else if (cnt != 10'd0)
							nxt.phase = pat_pkg::PH_ENTRY;
						else
							nxt.phase = pat_pkg::PH_CRC;
					end
				end
			end
			pat_pkg::PH_ENTRY, pat_pkg::PH_CRC: begin
				if (cur.byte_pos < 3'd3) begin
					nxt.collect_shift = {cur.collect_shift[15:0], section_byte};
					if (is_last) begin
						nxt.phase = pat_pkg::PH_HEADER;
						nxt.byte_pos = 3'd0;
					end else begin
						nxt.byte_pos = cur.byte_pos + 3'd1;
					end
				end else begin
					nxt.byte_pos = 3'd0;
					if (cur.phase == pat_pkg::PH_ENTRY) begin
						nxt.entries_left = left_dec;
						if (is_last)
							nxt.phase = pat_pkg::PH_HEADER;
						else if (left_dec != 10'd0)
							nxt.phase = pat_pkg::PH_ENTRY;
						else
							nxt.phase = pat_pkg::PH_CRC;
					end else begin
						nxt.phase = is_last ? pat_pkg::PH_HEADER : pat_pkg::PH_DONE;
					end
				end
			end
			default: begin
				if (is_last) begin
					nxt.phase = pat_pkg::PH_HEADER;
					nxt.byte_pos = 3'd0;
				end
			end
		endcase
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res = '0;
		case (cur.phase)
			pat_pkg::PH_HEADER: begin
				if (cur.byte_pos < 3'd7) begin
					res_valid = is_last;
					res.kind = pat_pkg::KIND_SHORT_HDR;
				end else begin
					res_valid = 1'b1;
					if (len_bad)
						res = header_result(cap, pat_pkg::KIND_BAD_LENGTH);
					else if (too_many)
						res = header_result(cap, pat_pkg::KIND_TOO_MANY);
					else if (is_last)
						res.kind = (cnt != 10'd0) ? pat_pkg::KIND_SHORT_ENTRY
							: pat_pkg::KIND_SHORT_CRC;
					else
						res = header_result(cap, pat_pkg::KIND_HEADER);
				end
			end
			pat_pkg::PH_ENTRY: begin
				if (cur.byte_pos < 3'd3) begin
					res_valid = is_last;
					res.kind = pat_pkg::KIND_SHORT_ENTRY;
				end else begin
					res_valid = 1'b1;
					if (is_last) begin
						res.kind = (left_dec != 10'd0) ? pat_pkg::KIND_SHORT_ENTRY
							: pat_pkg::KIND_SHORT_CRC;
					end else begin
						res.kind = pat_pkg::KIND_ENTRY;
						res.program_num = cur.collect_shift[23:8];
						res.map_pid = {cur.collect_shift[4:0], section_byte};
					end
				end
			end
			pat_pkg::PH_CRC: begin
				if (cur.byte_pos < 3'd3) begin
					res_valid = is_last;
					res.kind = pat_pkg::KIND_SHORT_CRC;
				end else begin
					res_valid = 1'b1;
					res.kind = pat_pkg::KIND_CRC;
					res.crc_word = {cur.collect_shift, section_byte};
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/pat_out_stage.sv
// result register with stream master handshake
module pat_out_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  pat_pkg::pat_result_t     in_result,
	output logic                     in_ready,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [pat_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [2:0]               m_tuser
);

	logic                 valid_q;
	pat_pkg::pat_result_t result_q;

	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q <= in_result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser = result_q.kind;
	assign m_tdata = {result_q.crc_word, result_q.map_pid, result_q.program_num,
		result_q.last_sect_number, result_q.sect_number, result_q.current_flag,
		result_q.version_num, result_q.stream_ident, result_q.sect_length,
		result_q.syntax_flag, result_q.table_ident};

endmodule

// File: rtl/pat_section_parser.sv
// top level of the program association section parser
// One section byte is taken per beat and a new byte can be taken every cycle unless a
// result is held up at the output. A byte passes through an input register and a
// single-pass parse step that updates the byte position, phase and header registers,
// and its result, if any, lands in an output register. At most one result follows
// from a byte: a header result on the eighth byte, one per four-byte program entry,
// one with the captured CRC word, or an error kind when the section is short, its
// length is below nine or it has more entries than max_programs. The CRC is not
// checked. After an error or the CRC, bytes are dropped until the byte marked last,
// and every byte marked last returns the parser to the start of a section.
module pat_section_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [9:0]   cfg_wr_data,   // max_programs
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,       // section_byte
	input  logic         s_tlast,       // is_last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,       // table_ident, syntax_flag, sect_length,
	                                    // stream_ident, version_num, current_flag,
	                                    // sect_number, last_sect_number, program_num,
	                                    // map_pid, crc_word
	output logic [2:0]   m_tuser        // result_kind
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic [9:0]           max_programs_q;
	pat_pkg::pat_state_t  state_q;
	pat_pkg::pat_state_t  state_nxt;
	logic                 res_valid;
	pat_pkg::pat_result_t res;
	logic                 out_ready;
	logic                 adv_s1;

	assign adv_s1 = valid_s1 && (!res_valid || out_ready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_programs_q <= pat_pkg::MAX_PROGRAMS_RESET;
		end else if (cfg_wr_en) begin
			max_programs_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pat_step u_step (
		.cur          (state_q),
		.max_programs (max_programs_q),
		.section_byte (byte_s1),
		.is_last      (last_s1),
		.nxt          (state_nxt),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: pat_pkg::PH_HEADER, default: '0};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	pat_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1 && res_valid),
		.in_result (res),
		.in_ready  (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

`ifndef NO_ASSERTIONS
	a_pos_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == pat_pkg::PH_ENTRY || state_q.phase == pat_pkg::PH_CRC)
		|-> state_q.byte_pos < 3'd4)
		else $error("byte position beyond a four-byte word");

	a_entries_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == pat_pkg::PH_ENTRY |-> state_q.entries_left != 10'd0)
		else $error("entry phase with no entries left");

	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == pat_pkg::PH_DONE |-> state_q.byte_pos == 3'd0)
		else $error("byte position not cleared while dropping bytes");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1 && $stable(state_q))
		else $error("parser state moved while the byte was stalled");
`endif

endmodule
